@@ rtl/satellite_table_with_aging_core_defines.svh @@
// Assertion macros shared by the checker
`ifndef SATELLITE_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define SATELLITE_TABLE_WITH_AGING_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define STWA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stwa check failed");

// next-cycle implication, sampled on clk, off while in reset
`define STWA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stwa check failed");

`endif

@@ rtl/stwa_pkg.sv @@
package stwa_pkg;

	localparam int MAX_RESULTS = 32;
	localparam logic [31:0] DEFAULT_MAX_AGE = 32'd30000;

	typedef enum logic [2:0] {
		CMD_UPSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_SWEEP  = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_SNAP   = 3'd4,
		CMD_LOOKUP = 3'd5
	} cmd_e;

	localparam logic [1:0] SORT_PRN = 2'd1;
	localparam logic [1:0] SORT_SNR = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_END
	} state_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [7:0]        prn;
		logic signed [7:0] elevation;
		logic [8:0]        azimuth;
		logic [6:0]        snr;
		logic [31:0]       now_ms;
		logic [1:0]        sort_mode;
	} in_t;

	typedef struct packed {
		logic              entry_valid;
		logic [7:0]        prn_out;
		logic signed [7:0] elevation_out;
		logic [8:0]        azimuth_out;
		logic [6:0]        snr_out;
		logic [31:0]       stamp_out;
		logic              last;
		logic [5:0]        sat_count;
		logic              status;
	} out_t;

	typedef struct packed {
		logic [7:0]        prn;
		logic signed [7:0] elevation;
		logic [8:0]        azimuth;
		logic [6:0]        snr;
		logic [31:0]       stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_empty;
		logic issue_last;
		logic snap_more;
	} stat_t;

endpackage

@@ rtl/stwa_ctrl.sv @@
module stwa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  stwa_pkg::stat_t stat,
	output stwa_pkg::ctrl_t ctrl,
	output logic            busy
);
	import stwa_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctrl = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_empty) begin
					state_d = ST_END;
				end else begin
					ctrl.issue = 1'b1;
					if (stat.issue_last) state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_END;
			end
			ST_END: begin
				ctrl.finish = 1'b1;
				state_d = stat.snap_more ? ST_SCAN : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/stwa_dp.sv @@
module stwa_dp #(
	parameter int MAX_SATS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  stwa_pkg::in_t   item,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_data,
	input  stwa_pkg::ctrl_t ctrl,
	output stwa_pkg::stat_t stat,
	output logic            done,
	output stwa_pkg::out_t  result
);
	import stwa_pkg::*;

	localparam int IW = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;
	localparam int CW = $clog2(MAX_SATS + 1);
	localparam int KW = 8 + IW;

	entry_t mem [MAX_SATS];

	in_t             in_q;
	logic [31:0]     max_age_q;
	logic [CW-1:0]   total_q, r_q, w_q, emit_q;
	logic            v_s1;
	logic [IW-1:0]   idx_s1;
	entry_t          rd_s1;
	logic            found_q, have_last_q;
	entry_t          hit_q;
	logic [KW-1:0]   best_q, last_q;

	logic            is_ups, is_del, is_swp, is_clr, is_snap, is_look, is_filter;
	logic            match, old, drop, better, append, full, snap_more;
	logic [31:0]     age;
	logic [7:0]      key8;
	logic [KW-1:0]   comp;
	logic [CW-1:0]   lim, next_total;
	entry_t          upd_e, wdata;
	logic            we;
	out_t            res_d;

	// command decode
	assign is_ups    = (in_q.command == CMD_UPSERT);
	assign is_del    = (in_q.command == CMD_DELETE);
	assign is_swp    = (in_q.command == CMD_SWEEP);
	assign is_clr    = (in_q.command == CMD_CLEAR);
	assign is_snap   = (in_q.command == CMD_SNAP);
	assign is_look   = (in_q.command == CMD_LOOKUP);
	assign is_filter = is_ups | is_del | is_swp;

	// per-entry tests on the entry just read
	assign match = (rd_s1.prn == in_q.prn);
	assign age   = in_q.now_ms - rd_s1.stamp;
	assign old   = (age > max_age_q);
	assign drop  = (is_del & match) | (is_ups & match & (in_q.snr == 7'd0)) | (is_swp & old);

	// sort key: entry index breaks ties, so keys are unique
	always_comb begin
		case (in_q.sort_mode)
			SORT_PRN: key8 = rd_s1.prn;
			SORT_SNR: key8 = {1'b0, ~rd_s1.snr};
			default:  key8 = 8'd0;
		endcase
	end
	assign comp   = {key8, idx_s1};
	assign better = (!have_last_q || comp > last_q) && (!found_q || comp < best_q);

	// snapshot length, capped at the result limit
	assign lim = (MAX_SATS > MAX_RESULTS && total_q > CW'(MAX_RESULTS)) ?
		CW'(MAX_RESULTS) : total_q;
	assign snap_more = is_snap && (CW'(emit_q + 1'b1) < lim);

	// upsert of a new key
	assign append = is_ups & !found_q & (in_q.snr != 7'd0) & (w_q < CW'(MAX_SATS));
	assign full   = is_ups & !found_q & (in_q.snr != 7'd0) & !append;

	always_comb begin
		if (is_filter)   next_total = w_q + CW'(append);
		else if (is_clr) next_total = '0;
		else             next_total = total_q;
	end

	assign upd_e = '{prn: in_q.prn, elevation: in_q.elevation, azimuth: in_q.azimuth,
		snr: in_q.snr, stamp: in_q.now_ms};

	// single write port: compaction during the scan, append at the end
	assign we    = (v_s1 & is_filter & !drop) | (ctrl.finish & append);
	assign wdata = (v_s1 && !(is_ups && match)) ? rd_s1 : upd_e;

	assign stat.scan_empty = (total_q == '0) || !(is_filter || is_snap || is_look);
	assign stat.issue_last = (r_q == total_q - 1'b1);
	assign stat.snap_more  = snap_more;

	// result of the item or of one snapshot pass
	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		res_d.sat_count = 6'(next_total);
		if (is_ups) begin
			res_d.status = full;
			if ((found_q && in_q.snr != 7'd0) || append) begin
				res_d.entry_valid   = 1'b1;
				res_d.prn_out       = upd_e.prn;
				res_d.elevation_out = upd_e.elevation;
				res_d.azimuth_out   = upd_e.azimuth;
				res_d.snr_out       = upd_e.snr;
				res_d.stamp_out     = upd_e.stamp;
			end
		end else if ((is_look && found_q) || (is_snap && total_q != '0)) begin
			res_d.entry_valid   = 1'b1;
			res_d.prn_out       = hit_q.prn;
			res_d.elevation_out = hit_q.elevation;
			res_d.azimuth_out   = hit_q.azimuth;
			res_d.snr_out       = hit_q.snr;
			res_d.stamp_out     = hit_q.stamp;
			res_d.last          = !snap_more;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem[w_q[IW-1:0]] <= wdata;
		if (ctrl.issue) begin
			rd_s1  <= mem[r_q[IW-1:0]];
			idx_s1 <= r_q[IW-1:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load) in_q <= item;
		if (v_s1 && ((is_look && match) || (is_snap && better))) hit_q <= rd_s1;
		if (v_s1 && is_snap && better) best_q <= comp;
		if (ctrl.finish && is_snap) last_q <= best_q;
		if (ctrl.finish) result <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q   <= DEFAULT_MAX_AGE;
			total_q     <= '0;
			r_q         <= '0;
			w_q         <= '0;
			emit_q      <= '0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			have_last_q <= 1'b0;
			done        <= 1'b0;
		end else begin
			if (cfg_we) max_age_q <= cfg_data;
			v_s1 <= ctrl.issue;
			done <= ctrl.finish;
			if (ctrl.load) begin
				r_q         <= '0;
				w_q         <= '0;
				emit_q      <= '0;
				found_q     <= 1'b0;
				have_last_q <= 1'b0;
			end
			if (ctrl.issue) r_q <= r_q + 1'b1;
			if (v_s1) begin
				if (is_filter && !drop) w_q <= w_q + 1'b1;
				if ((is_filter || is_look) && match) found_q <= 1'b1;
				if (is_snap && better) found_q <= 1'b1;
			end
			if (ctrl.finish) begin
				if (is_filter || is_clr) total_q <= next_total;
				if (is_snap) begin
					have_last_q <= 1'b1;
					found_q     <= 1'b0;
					r_q         <= '0;
					emit_q      <= emit_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/satellite_table_with_aging_core.sv @@
// channel   ports                      transfer
// item      start, busy, item          start high while busy low
// result    done, result               done high, one cycle, no back-pressure
// config    cfg_we, cfg_data           cfg_we high (max_age_ms)
//
// Upsert, delete, sweep and lookup walk the table once for n entries. Clear
// and unused commands do not walk the table. A snapshot does one pass per
// result, min(n, 32) passes, each pass a read of the table through the
// single read port of the table memory.
// Reset empties the table at once; there is no clearing pass.
module satellite_table_with_aging_core #(
	parameter int MAX_SATS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  stwa_pkg::in_t  item,
	output logic           done,
	output stwa_pkg::out_t result,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_data
);
	import stwa_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	stwa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	stwa_dp #(.MAX_SATS(MAX_SATS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

endmodule

@@ rtl/stwa_checker.sv @@
`include "satellite_table_with_aging_core_defines.svh"

module stwa_checker #(
	parameter int MAX_SATS = 32
) (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input stwa_pkg::out_t result
);
	import stwa_pkg::*;

	// an accepted item keeps the block busy
	`STWA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
	// a dropped insert never reports an entry
	`STWA_ASSERT_NOW(a_drop_no_entry, done && result.status, !result.entry_valid && result.last)
	// the final result of an item is not followed at once by another
	`STWA_ASSERT_NEXT(a_gap_after_last, done && result.last, !done)
	// count never exceeds the table size
	`STWA_ASSERT_NOW(a_count_range, done, {1'b0, result.sat_count} <= 7'(MAX_SATS))

endmodule

bind satellite_table_with_aging_core stwa_checker #(.MAX_SATS(MAX_SATS)) u_stwa_checker (.*);
